// ===== hw/rtl/neighbour_discovery_table_macros.svh =====
// Assertion macros for the neighbour discovery table checker.
// Needs no other file; included by the checker module only.
`ifndef NEIGHBOUR_DISCOVERY_TABLE_MACROS_SVH
`define NEIGHBOUR_DISCOVERY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ndt_pkg.sv =====
// Shared types and constants of the neighbour discovery table.
// No dependencies; imported by ndt_cell, neighbour_discovery_table and ndt_checker.
package ndt_pkg;

	localparam int ADDR_W  = 16;
	localparam int ID_W    = 32;
	localparam int IDX_W   = 8;
	localparam int DUR_W   = 32;
	localparam int DELAY_W = 31;

	typedef enum logic [3:0] {
		OP_BEACON   = 4'd0,
		OP_QUERY    = 4'd1,
		OP_DISCOVER = 4'd2,
		OP_DEAD     = 4'd3,
		OP_CLEAR    = 4'd4,
		OP_START    = 4'd5,
		OP_STOP     = 4'd6,
		OP_ENABLE   = 4'd7,
		OP_DISABLE  = 4'd8
	} op_t;

	// Token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic              valid;
		logic              fired;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic              hit;
		logic              free_seen;
	} token_t;

endpackage

// ===== hw/rtl/neighbour_discovery_table.sv =====
// Neighbour discovery table: one item in, one result beat out, per operation.
// An accepted item becomes a token that walks a chain of NEIGHBOUR_SLOTS table
// cells, one cell per clock. Each cell compares its stored link address, frees
// itself on a clear or a matching neighbour death, and marks itself when it is
// the first free slot. When the token leaves the last cell the result is known:
// an unknown beacon is written into the marked cell (or dropped when the table
// is full), the enable flag and schedule index are updated, and the result beat
// is loaded into the output register. The token passes the entry register and then
// the register of each cell in turn before its result is loaded. The block takes
// no new input beat until the token of the last one has left the chain's tail;
// in_stall stays high while an item is in flight. A finished result waiting in
// the output register does not block the next input beat; it only holds the token
// at the chain's tail.
// Depends on ndt_pkg and ndt_cell.
module neighbour_discovery_table import ndt_pkg::*; #(
	parameter int NEIGHBOUR_SLOTS = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: own node id.
	input  logic              cfg_wr_en,
	input  logic [ID_W-1:0]   cfg_wr_data,
	// Input channel.
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        operation,
	input  logic [ADDR_W-1:0] neighbour_addr,
	input  logic [ID_W-1:0]   peer_node_id,
	input  logic [IDX_W-1:0]  peer_sched_index,
	input  logic [IDX_W-1:0]  start_index,
	input  logic [DUR_W-1:0]  phase_duration,
	input  logic              timer_fired,
	// Output channel.
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_known,
	output logic              send_beacon,
	output logic [IDX_W-1:0]  beacon_sched_index,
	output logic              adopt_index,
	output logic [IDX_W-1:0]  adopted_index,
	output logic              notify_agent,
	output logic              arm_timer,
	output logic [DELAY_W-1:0] timer_delay,
	output logic              cancel_timer
);

	// Control state.
	logic busy_q;
	logic enabled_q;
	logic [IDX_W-1:0] sched_q;
	logic [ID_W-1:0]  own_id_q;
	logic out_valid_q;

	// Item payload held while its token walks the chain.
	logic [ID_W-1:0]    peer_id_q;
	logic [IDX_W-1:0]   peer_idx_q;
	logic [IDX_W-1:0]   start_idx_q;
	logic [DELAY_W-1:0] half_dur_q;

	// Output payload registers.
	logic               known_q;
	logic               beacon_q;
	logic [IDX_W-1:0]   beacon_idx_q;
	logic               adopt_q;
	logic [IDX_W-1:0]   adopted_q;
	logic               notify_q;
	logic               arm_q;
	logic [DELAY_W-1:0] delay_q;
	logic               cancel_q;

	token_t tok [NEIGHBOUR_SLOTS+1];
	token_t tok_entry_q;
	token_t tok_new;
	token_t tail;

	logic accept;
	logic finalize;
	logic store_en;

	// Result of the token at the tail, and the state update it causes.
	logic               r_known;
	logic               r_beacon;
	logic [IDX_W-1:0]   r_beacon_idx;
	logic               r_adopt;
	logic [IDX_W-1:0]   r_adopted;
	logic               r_notify;
	logic               r_arm;
	logic [DELAY_W-1:0] r_delay;
	logic               r_cancel;
	logic               r_enabled;
	logic [IDX_W-1:0]   r_sched;

	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;

	assign tok[0] = tok_entry_q;
	assign tail   = tok[NEIGHBOUR_SLOTS];

	// The tail token retires when the output register is empty or draining.
	assign finalize = tail.valid && (!out_valid_q || !out_stall);

	// A beacon from an unknown address is stored only if some slot was free.
	assign store_en = finalize && !tail.fired && (tail.op == OP_BEACON)
		&& !tail.hit && tail.free_seen;

	genvar gi;
	generate
		for (gi = 0; gi < NEIGHBOUR_SLOTS; gi++) begin : g_cell
			logic cell_hold;
			// Only the last cell may have to keep its token.
			assign cell_hold = (gi == NEIGHBOUR_SLOTS - 1) ? !finalize : 1'b0;
			ndt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tok_in     (tok[gi]),
				.hold       (cell_hold),
				.store_en   (store_en),
				.store_addr (tail.addr),
				.tok_out    (tok[gi+1])
			);
		end
	endgenerate

	// Token built from the input beat; it starts with no hit and no free slot.
	always_comb begin
		tok_new           = '0;
		tok_new.valid     = 1'b1;
		tok_new.fired     = timer_fired;
		tok_new.op        = op_t'(operation);
		tok_new.addr      = neighbour_addr;
		tok_new.hit       = 1'b0;
		tok_new.free_seen = 1'b0;
	end

	// Entry stage of the chain and the busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_entry_q <= '0;
			busy_q      <= 1'b0;
		end else begin
			if (accept) begin
				tok_entry_q <= tok_new;
			end else begin
				tok_entry_q.valid <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finalize) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			peer_id_q   <= peer_node_id;
			peer_idx_q  <= peer_sched_index;
			start_idx_q <= start_index;
			half_dur_q  <= phase_duration[DUR_W-1:1];
		end
	end

	// Decide the result once the whole table has been seen.
	always_comb begin
		r_known   = 1'b0;
		r_beacon  = 1'b0;
		r_adopt   = 1'b0;
		r_adopted = '0;
		r_notify  = 1'b0;
		r_arm     = 1'b0;
		r_delay   = '0;
		r_cancel  = 1'b0;
		r_enabled = enabled_q;
		r_sched   = sched_q;
		if (tail.fired) begin
			// Half-phase timer expiry overrides the operation code.
			r_beacon = enabled_q;
		end else begin
			case (tail.op)
				OP_BEACON: begin
					r_known  = tail.hit;
					r_notify = 1'b1;
					if (!tail.hit) begin
						r_beacon = enabled_q;
						if (peer_id_q > own_id_q) begin
							r_adopt   = 1'b1;
							r_adopted = peer_idx_q;
						end
					end
				end
				OP_QUERY: begin
					r_known = tail.hit;
				end
				OP_DISCOVER: begin
					r_known  = tail.hit;
					r_beacon = !tail.hit && enabled_q;
				end
				OP_DEAD: begin
					r_known = tail.hit;
				end
				OP_CLEAR: begin
					// The cells have already dropped their entries.
				end
				OP_START: begin
					r_sched   = start_idx_q;
					r_enabled = 1'b1;
					r_beacon  = 1'b1;
					r_arm     = 1'b1;
					r_delay   = half_dur_q;
				end
				OP_STOP: begin
					r_cancel  = 1'b1;
					r_beacon  = enabled_q;
					r_enabled = 1'b0;
				end
				OP_ENABLE: begin
					r_enabled = 1'b1;
				end
				OP_DISABLE: begin
					r_enabled = 1'b0;
				end
				default: begin
					// Unused codes give an all-zero result.
				end
			endcase
		end
		// The beacon carries the index as it stands after this item.
		r_beacon_idx = r_beacon ? r_sched : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			sched_q     <= '0;
			own_id_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				own_id_q <= cfg_wr_data;
			end
			if (finalize) begin
				enabled_q <= r_enabled;
				sched_q   <= r_sched;
			end
			if (finalize) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finalize) begin
			known_q      <= r_known;
			beacon_q     <= r_beacon;
			beacon_idx_q <= r_beacon_idx;
			adopt_q      <= r_adopt;
			adopted_q    <= r_adopted;
			notify_q     <= r_notify;
			arm_q        <= r_arm;
			delay_q      <= r_delay;
			cancel_q     <= r_cancel;
		end
	end

	assign out_valid          = out_valid_q;
	assign is_known           = known_q;
	assign send_beacon        = beacon_q;
	assign beacon_sched_index = beacon_idx_q;
	assign adopt_index        = adopt_q;
	assign adopted_index      = adopted_q;
	assign notify_agent       = notify_q;
	assign arm_timer          = arm_q;
	assign timer_delay        = delay_q;
	assign cancel_timer       = cancel_q;

endmodule

// ===== hw/rtl/ndt_cell.sv =====
// One slot of the neighbour table with its stage of the token chain.
// Depends on ndt_pkg.
module ndt_cell import ndt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  token_t            tok_in,
	input  logic              hold,
	input  logic              store_en,
	input  logic [ADDR_W-1:0] store_addr,
	output token_t            tok_out
);

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic              cand_q;
	token_t            tok_q;
	token_t            tok_next;
	logic              act;
	logic              match;

	assign act   = tok_in.valid && !tok_in.fired;
	assign match = valid_q && (addr_q == tok_in.addr);

	// The token leaves this cell with its hit and free marks brought up to date.
	always_comb begin
		tok_next           = tok_in;
		tok_next.hit       = tok_in.hit | match;
		tok_next.free_seen = tok_in.free_seen | !valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
		end else begin
			if (store_en && cand_q) begin
				valid_q <= 1'b1;
			end else if (act && (tok_in.op == OP_CLEAR || (tok_in.op == OP_DEAD && match))) begin
				valid_q <= 1'b0;
			end
			// The first free slot along the chain is the candidate for a store.
			if (tok_in.valid) begin
				cand_q <= !valid_q && !tok_in.free_seen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en && cand_q) begin
			addr_q <= store_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.valid) begin
			tok_q <= tok_next;
		end else if (!hold) begin
			tok_q.valid <= 1'b0;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/ndt_checker.sv =====
// Port-level assertions for the neighbour discovery table, bound to the top level.
// Depends on ndt_pkg and neighbour_discovery_table_macros.svh.
`include "neighbour_discovery_table_macros.svh"

module ndt_checker import ndt_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               is_known,
	input logic               send_beacon,
	input logic [IDX_W-1:0]   beacon_sched_index,
	input logic               adopt_index,
	input logic [IDX_W-1:0]   adopted_index,
	input logic               notify_agent,
	input logic               arm_timer,
	input logic [DELAY_W-1:0] timer_delay,
	input logic               cancel_timer
);

	localparam int PAYLOAD_W = 6 + 2 * IDX_W + DELAY_W;

	logic [PAYLOAD_W-1:0] out_payload;
	logic                 fields_clean;

	assign out_payload = {is_known, send_beacon, beacon_sched_index, adopt_index,
		adopted_index, notify_agent, arm_timer, timer_delay, cancel_timer};

	assign fields_clean = (send_beacon || beacon_sched_index == '0)
		&& (adopt_index || adopted_index == '0) && (arm_timer || timer_delay == '0);

	// A stalled result beat keeps its valid and its payload.
	`NDT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_payload), "stalled result beat changed")

	// Only one item is in flight: after an input beat the block stalls.
	`NDT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall, "second item taken")

	// Index and delay fields are zero unless their flag is set.
	`NDT_ASSERT_NOW(a_zero_fields, clk, arst_n, out_valid, fields_clean, "field set without its flag")

	// Adoption comes only from a received beacon, which always notifies the agent.
	`NDT_ASSERT_NOW(a_adopt_notify, clk, arst_n, out_valid && adopt_index, notify_agent, "adopt without notice")

	// A phase start always answers with a beacon and neither cancels nor notifies the agent.
	`NDT_ASSERT_NOW(a_arm_beacon, clk, arst_n, out_valid && arm_timer, send_beacon && !cancel_timer && !notify_agent, "arm without beacon")

endmodule

bind neighbour_discovery_table ndt_checker u_ndt_checker (.*);
